// File: hdl/alb_pkg.sv
// ----------------------------------------------------------------------------
// alb_pkg
// Shared types and constants for the andon light and buzzer controller.
// ----------------------------------------------------------------------------
`default_nettype none

package alb_pkg;

    typedef enum logic [1:0] {
        MODE_GREEN  = 2'd0,
        MODE_YELLOW = 2'd1,
        MODE_RED    = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode mode;
        logic  buzzer;
    } t_status;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned TH_W = 11;
    localparam int unsigned LEVEL_W = 8;

    localparam logic [TIME_W-1:0] ENTRY_DELAY_MS = 32'd500;

    localparam logic [TH_W-1:0] TH_GREEN_ON   = 11'd2000;
    localparam logic [TH_W-1:0] TH_GREEN_OFF  = 11'd200;
    localparam logic [TH_W-1:0] TH_YELLOW_P0  = 11'd500;
    localparam logic [TH_W-1:0] TH_YELLOW_P1  = 11'd150;
    localparam logic [TH_W-1:0] TH_YELLOW_P2  = 11'd250;
    localparam logic [TH_W-1:0] TH_YELLOW_P3  = 11'd150;
    localparam logic [TH_W-1:0] TH_RED_TOGGLE = 11'd100;

    // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
    localparam int unsigned RECIP_W = 29;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h10624DD3;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned PROD_W = TIME_W + RECIP_W;
    localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;

    localparam int unsigned REM_W = 10;
    localparam logic [REM_W-1:0] BLANK_PERIOD_MS = 10'd1000;
    localparam logic [REM_W-1:0] BLANK_LEN_MS = 10'd100;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;

endpackage

`default_nettype wire

// File: hdl/alb_state.sv
// ----------------------------------------------------------------------------
// alb_state
// Mode selection, buzzer phase sequencing and event time register.
// ----------------------------------------------------------------------------
`default_nettype none

module alb_state (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [alb_pkg::TIME_W-1:0]  i_now,
    input  wire logic                        i_red,
    input  wire logic                        i_yellow,
    input  wire logic                        i_green,
    output alb_pkg::t_status                 o_status
);

    alb_pkg::t_mode               r_mode;
    alb_pkg::t_mode               n_mode;
    logic [alb_pkg::PHASE_W-1:0]  r_phase;
    logic [alb_pkg::PHASE_W-1:0]  n_phase;
    logic [alb_pkg::TIME_W-1:0]   r_last;
    logic [alb_pkg::TIME_W-1:0]   n_last;

    logic                         w_any;
    logic                         w_changed;
    logic                         w_own;
    logic                         w_has_rule;
    logic [alb_pkg::TH_W-1:0]     w_th;
    logic [alb_pkg::PHASE_W-1:0]  w_next;
    logic [alb_pkg::TIME_W-1:0]   w_elapsed;
    logic                         w_fire;

    always_comb begin
        w_any = i_red | i_yellow | i_green;
        if (i_red) begin
            n_mode = alb_pkg::MODE_RED;
        end else if (i_yellow) begin
            n_mode = alb_pkg::MODE_YELLOW;
        end else if (i_green) begin
            n_mode = alb_pkg::MODE_GREEN;
        end else begin
            n_mode = r_mode;
        end
        w_changed = w_any && (n_mode != r_mode);

        case (n_mode)
            alb_pkg::MODE_GREEN:  w_own = i_green;
            alb_pkg::MODE_YELLOW: w_own = i_yellow;
            alb_pkg::MODE_RED:    w_own = i_red;
            default:              w_own = 1'b0;
        endcase

        w_has_rule = 1'b1;
        w_th       = alb_pkg::TH_RED_TOGGLE;
        w_next     = 2'd0;
        case (n_mode)
            alb_pkg::MODE_GREEN: begin
                case (r_phase)
                    2'd0: begin w_th = alb_pkg::TH_GREEN_ON;  w_next = 2'd1; end
                    2'd1: begin w_th = alb_pkg::TH_GREEN_OFF; w_next = 2'd0; end
                    default: w_has_rule = 1'b0;
                endcase
            end
            alb_pkg::MODE_YELLOW: begin
                case (r_phase)
                    2'd0: begin w_th = alb_pkg::TH_YELLOW_P0; w_next = 2'd1; end
                    2'd1: begin w_th = alb_pkg::TH_YELLOW_P1; w_next = 2'd2; end
                    2'd2: begin w_th = alb_pkg::TH_YELLOW_P2; w_next = 2'd3; end
                    default: begin w_th = alb_pkg::TH_YELLOW_P3; w_next = 2'd0; end
                endcase
            end
            alb_pkg::MODE_RED: begin
                case (r_phase)
                    2'd0: begin w_th = alb_pkg::TH_RED_TOGGLE; w_next = 2'd1; end
                    2'd1: begin w_th = alb_pkg::TH_RED_TOGGLE; w_next = 2'd0; end
                    default: w_has_rule = 1'b0;
                endcase
            end
            default: w_has_rule = 1'b0;
        endcase

        // a fresh mode entry never fires; it sets the event time to now+500 (red, yellow) or now (green)
        w_elapsed = i_now - r_last;
        w_fire    = !w_changed && w_own && w_has_rule && !w_elapsed[alb_pkg::TIME_W-1]
                    && (w_elapsed >= {{(alb_pkg::TIME_W-alb_pkg::TH_W){1'b0}}, w_th});

        if (!w_own) begin
            n_phase = 2'd0;
        end else if (w_fire) begin
            n_phase = w_next;
        end else begin
            n_phase = r_phase;
        end

        if (w_changed) begin
            n_last = (i_red | i_yellow) ? (i_now + alb_pkg::ENTRY_DELAY_MS) : i_now;
        end else if (w_fire) begin
            n_last = i_now;
        end else begin
            n_last = r_last;
        end

        o_status.mode   = n_mode;
        o_status.buzzer = n_phase[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= alb_pkg::MODE_GREEN;
            r_phase <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_last  <= n_last;
        end
    end

    a_red_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_red |=> r_mode == alb_pkg::MODE_RED)
        else $error("red press did not select red mode");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !w_own |=> r_phase == 2'd0)
        else $error("phase not cleared on release");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_last) && $stable(r_mode))
        else $error("state changed without a step");

    a_entry_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_changed && w_own |=> r_phase == $past(r_phase))
        else $error("phase advanced on mode entry");

endmodule

`default_nettype wire

// File: hdl/alb_blank.sv
// ----------------------------------------------------------------------------
// alb_blank
// Two-stage time mod 1000 check: reciprocal multiply, then remainder compare.
// ----------------------------------------------------------------------------
`default_nettype none

module alb_blank (
    input  wire logic                        i_clk,
    input  wire logic                        i_load,
    input  wire logic [alb_pkg::TIME_W-1:0]  i_now,
    output logic                             o_blank
);

    logic [alb_pkg::PROD_W-1:0]  w_prod;
    logic [alb_pkg::QUOT_W-1:0]  r_quot;
    logic [alb_pkg::REM_W-1:0]   r_now_lo;
    logic [alb_pkg::REM_W-1:0]   w_qk_lo;
    logic [alb_pkg::REM_W-1:0]   w_rem;

    assign w_prod = {{alb_pkg::RECIP_W{1'b0}}, i_now}
                  * {{alb_pkg::TIME_W{1'b0}}, alb_pkg::RECIP_1000};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot   <= w_prod[alb_pkg::PROD_W-1:alb_pkg::RECIP_SHIFT];
            r_now_lo <= i_now[alb_pkg::REM_W-1:0];
        end
    end

    // remainder is below 1024, so the low bits of the difference are exact
    assign w_qk_lo = r_quot[alb_pkg::REM_W-1:0] * alb_pkg::BLANK_PERIOD_MS;
    assign w_rem   = r_now_lo - w_qk_lo;
    assign o_blank = (w_rem < alb_pkg::BLANK_LEN_MS);

endmodule

`default_nettype wire

// File: hdl/andon_light_buzzer_controller_core.sv
// ----------------------------------------------------------------------------
// andon_light_buzzer_controller_core
// Button sampled andon lamp, pixel and buzzer controller, three-stage pipe.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   sample   | in        | i_valid / o_ready  | i_now_ms, i_*_pressed
//   result   | out       | o_valid / i_ready  | o_mode, lamps, o_buzzer, o_pixel_*
//
// one transfer per clock sustained while results are taken downstream
// a sample passes the input register, the multiply register and the result register
// mode, phase and event time update in the cycle a sample leaves the input register
// synchronous active-low reset empties every stage and restores green mode
// a stalled result holds its stage; upstream stages keep filling until full
// ----------------------------------------------------------------------------
`default_nettype none

module andon_light_buzzer_controller_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [alb_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic                          i_red_pressed,
    input  wire logic                          i_yellow_pressed,
    input  wire logic                          i_green_pressed,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_mode,
    output logic                               o_red_lamp,
    output logic                               o_yellow_lamp,
    output logic                               o_green_lamp,
    output logic                               o_buzzer,
    output logic [alb_pkg::LEVEL_W-1:0]        o_pixel_red,
    output logic [alb_pkg::LEVEL_W-1:0]        o_pixel_green
);

    logic                          r_s1_vld;
    logic [alb_pkg::TIME_W-1:0]    r_s1_now;
    logic                          r_s1_red;
    logic                          r_s1_yellow;
    logic                          r_s1_green;

    logic                          r_s2_vld;
    alb_pkg::t_status              r_s2_status;

    logic                          r_o_vld;
    logic [1:0]                    r_o_mode;
    logic                          r_o_red_lamp;
    logic                          r_o_yellow_lamp;
    logic                          r_o_green_lamp;
    logic                          r_o_buzzer;
    logic [alb_pkg::LEVEL_W-1:0]   r_o_pixel_red;
    logic [alb_pkg::LEVEL_W-1:0]   r_o_pixel_green;

    logic                          w_out_rdy;
    logic                          w_s2_rdy;
    logic                          w_s1_rdy;
    logic                          w_s1_move;
    logic                          w_s2_move;
    alb_pkg::t_status              w_status;
    logic                          w_blank;

    assign w_out_rdy = !r_o_vld || i_ready;
    assign w_s2_rdy  = !r_s2_vld || w_out_rdy;
    assign w_s1_rdy  = !r_s1_vld || w_s2_rdy;
    assign w_s1_move = r_s1_vld && w_s2_rdy;
    assign w_s2_move = r_s2_vld && w_out_rdy;

    alb_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_s1_move),
        .i_now    (r_s1_now),
        .i_red    (r_s1_red),
        .i_yellow (r_s1_yellow),
        .i_green  (r_s1_green),
        .o_status (w_status)
    );

    alb_blank u_blank (
        .i_clk   (i_clk),
        .i_load  (w_s1_move),
        .i_now   (r_s1_now),
        .o_blank (w_blank)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_s1_rdy) begin
                r_s1_vld <= i_valid;
            end
            if (w_s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_out_rdy) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_s1_rdy && i_valid) begin
            r_s1_now    <= i_now_ms;
            r_s1_red    <= i_red_pressed;
            r_s1_yellow <= i_yellow_pressed;
            r_s1_green  <= i_green_pressed;
        end
        if (w_s1_move) begin
            r_s2_status <= w_status;
        end
        if (w_s2_move) begin
            r_o_mode        <= r_s2_status.mode;
            r_o_red_lamp    <= (r_s2_status.mode == alb_pkg::MODE_RED);
            r_o_yellow_lamp <= (r_s2_status.mode == alb_pkg::MODE_YELLOW);
            r_o_green_lamp  <= (r_s2_status.mode == alb_pkg::MODE_GREEN);
            r_o_buzzer      <= r_s2_status.buzzer;
            r_o_pixel_red   <= (!w_blank && r_s2_status.mode != alb_pkg::MODE_GREEN)
                               ? alb_pkg::FULL_LEVEL : '0;
            r_o_pixel_green <= (!w_blank && r_s2_status.mode != alb_pkg::MODE_RED)
                               ? alb_pkg::FULL_LEVEL : '0;
        end
    end

    assign o_ready       = w_s1_rdy;
    assign o_valid       = r_o_vld;
    assign o_mode        = r_o_mode;
    assign o_red_lamp    = r_o_red_lamp;
    assign o_yellow_lamp = r_o_yellow_lamp;
    assign o_green_lamp  = r_o_green_lamp;
    assign o_buzzer      = r_o_buzzer;
    assign o_pixel_red   = r_o_pixel_red;
    assign o_pixel_green = r_o_pixel_green;

endmodule

`default_nettype wire
